// ===== design/twc_pkg.sv =====
package twc_pkg;

    // Timer rate in ticks per second; the remainder width and the scaling constants are derived from it.
    localparam int TICKS_PER_SECOND = 100;

    localparam int MICROS_PER_SEC  = 1000000;
    localparam int MICROS_PER_TICK = MICROS_PER_SEC / TICKS_PER_SECOND;
    localparam int MS_PER_TICK     = 1000 / TICKS_PER_SECOND;

    // Remainder of the elapsed ticks by the tick rate.
    localparam int REM_W = $clog2(TICKS_PER_SECOND) + 1;

    // floor(2^32 / rate): the estimate it gives is the true quotient or one short.
    localparam logic [32:0] TICK_RECIP = 33'((64'd1 << 32) / 64'(TICKS_PER_SECOND));

    // ceil(2^40 / micros per tick): exact quotient for any 20-bit fraction.
    localparam int FRAC_W     = 20;
    localparam int FRAC_SHIFT = 40;
    localparam logic [40:0] FRAC_RECIP =
        41'(((64'd1 << FRAC_SHIFT) + 64'(MICROS_PER_TICK) - 64'd1) / 64'(MICROS_PER_TICK));

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_READ = 2'd1,
        MODE_SET  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_ARG    = 2'd1,
        STATUS_NO_RTC     = 2'd2,
        STATUS_WRITE_FAIL = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PHASE_UNKNOWN = 3'b001,
        PHASE_WATCH   = 3'b010,
        PHASE_SET     = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic              rtc_present;
        logic [31:0]       rtc_second;
        logic              rtc_write_ok;
        logic signed [31:0] new_second;
        logic signed [31:0] new_micros;
        logic [FRAC_W-1:0] frac_ticks;
    } item_t;

    typedef struct packed {
        logic [31:0] tick;
        logic [31:0] elapsed;
        logic [31:0] base_or_raw;
        logic        use_elapsed;
        status_t     status;
        logic        aligned;
    } exec_res_t;

    typedef struct packed {
        logic [31:0] tick;
        logic [31:0] uptime;
        logic [31:0] elapsed;
        logic [31:0] q_est;
        logic [31:0] base_or_raw;
        logic        use_elapsed;
        status_t     status;
        logic        aligned;
    } quot_res_t;

    typedef struct packed {
        logic [31:0]      tick;
        logic [31:0]      uptime;
        logic [31:0]      quot;
        logic [REM_W-1:0] rem;
        logic [31:0]      base_or_raw;
        logic             use_elapsed;
        status_t          status;
        logic             aligned;
    } div_res_t;

endpackage

// ===== design/twc_exec.sv =====
module twc_exec (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  twc_pkg::item_t    item,
    output twc_pkg::exec_res_t res_reg
);
    import twc_pkg::*;

    logic [31:0] tick_reg, tick_next;
    logic [31:0] base_second_reg, base_second_next;
    logic [31:0] base_tick_reg, base_tick_next;
    logic [31:0] watched_reg, watched_next;
    phase_t      phase_reg, phase_next;
    exec_res_t   res_next;
    logic [31:0] tick_inc;
    logic        bad_arg;

    assign tick_inc = tick_reg + 32'd1;
    assign bad_arg  = item.new_second[31] || item.new_micros[31]
                      || (item.new_micros[30:0] >= 31'(MICROS_PER_SEC));

    always_comb
    begin
        tick_next        = tick_reg;
        base_second_next = base_second_reg;
        base_tick_next   = base_tick_reg;
        watched_next     = watched_reg;
        phase_next       = phase_reg;

        res_next.tick        = tick_reg;
        res_next.elapsed     = tick_reg - base_tick_reg;
        res_next.base_or_raw = 32'd0;
        res_next.use_elapsed = 1'b0;
        res_next.status      = STATUS_OK;

        unique case (item.mode)
            MODE_TICK:
            begin
                tick_next     = tick_inc;
                res_next.tick = tick_inc;
                if (phase_reg != PHASE_SET && item.rtc_present)
                begin
                    if (phase_reg == PHASE_UNKNOWN)
                    begin
                        watched_next = item.rtc_second;
                        phase_next   = PHASE_WATCH;
                    end
                    else if (item.rtc_second != watched_reg)
                    begin
                        base_second_next = item.rtc_second;
                        base_tick_next   = tick_inc;
                        phase_next       = PHASE_SET;
                    end
                end
            end
            MODE_SET:
            begin
                priority if (bad_arg)
                    res_next.status = STATUS_BAD_ARG;
                else if (!item.rtc_present)
                    res_next.status = STATUS_NO_RTC;
                else if (!item.rtc_write_ok)
                    res_next.status = STATUS_WRITE_FAIL;
                else
                begin
                    base_second_next = item.new_second;
                    base_tick_next   = tick_reg - 32'(item.frac_ticks);
                    phase_next       = PHASE_SET;
                end
            end
            default:
            begin
                // Read; the unused mode code reads as well.
                if (phase_reg == PHASE_SET)
                begin
                    res_next.use_elapsed = 1'b1;
                    res_next.base_or_raw = base_second_reg;
                end
                else
                begin
                    res_next.base_or_raw = item.rtc_present ? item.rtc_second : 32'd0;
                end
            end
        endcase

        res_next.aligned = (phase_next == PHASE_SET);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= '0;
            base_second_reg <= '0;
            base_tick_reg   <= '0;
            watched_reg     <= '0;
            phase_reg       <= PHASE_UNKNOWN;
        end
        else if (adv)
        begin
            tick_reg        <= tick_next;
            base_second_reg <= base_second_next;
            base_tick_reg   <= base_tick_next;
            watched_reg     <= watched_next;
            phase_reg       <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

endmodule

// ===== design/twc_div.sv =====
module twc_div (
    input  logic               clk,
    input  logic               en_quot,
    input  logic               en_rem,
    input  twc_pkg::exec_res_t exec_res,
    output twc_pkg::div_res_t  div_reg
);
    import twc_pkg::*;

    quot_res_t   quot_reg, quot_next;
    div_res_t    div_next;
    logic [64:0] recip_prod;
    logic [31:0] back_prod;
    logic [31:0] rem_raw;

    // Reciprocal estimate of elapsed / rate, and the uptime in milliseconds.
    assign recip_prod = 65'(exec_res.elapsed) * 65'(TICK_RECIP);

    always_comb
    begin
        quot_next.tick        = exec_res.tick;
        quot_next.uptime      = exec_res.tick * 32'(MS_PER_TICK);
        quot_next.elapsed     = exec_res.elapsed;
        quot_next.q_est       = recip_prod[63:32];
        quot_next.base_or_raw = exec_res.base_or_raw;
        quot_next.use_elapsed = exec_res.use_elapsed;
        quot_next.status      = exec_res.status;
        quot_next.aligned     = exec_res.aligned;
    end

    // The estimate is at most one short: one compare and subtract fixes it.
    assign back_prod = quot_reg.q_est * 32'(TICKS_PER_SECOND);
    assign rem_raw   = quot_reg.elapsed - back_prod;

    always_comb
    begin
        div_next.tick        = quot_reg.tick;
        div_next.uptime      = quot_reg.uptime;
        div_next.base_or_raw = quot_reg.base_or_raw;
        div_next.use_elapsed = quot_reg.use_elapsed;
        div_next.status      = quot_reg.status;
        div_next.aligned     = quot_reg.aligned;
        if (rem_raw >= 32'(TICKS_PER_SECOND))
        begin
            div_next.quot = quot_reg.q_est + 32'd1;
            div_next.rem  = REM_W'(rem_raw - 32'(TICKS_PER_SECOND));
        end
        else
        begin
            div_next.quot = quot_reg.q_est;
            div_next.rem  = REM_W'(rem_raw);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_quot)
            quot_reg <= quot_next;
        if (en_rem)
            div_reg <= div_next;
    end

endmodule

// ===== design/tick_wall_clock_core.sv =====
// Wall clock kept from a timer tick and a whole-second RTC.
//
// Items arrive on the s_ stream: s_tuser carries the item kind (timer tick,
// read clock or set clock) and s_tdata the RTC observations and the set
// arguments. Every accepted item yields exactly one transfer on the m_
// stream, in order, carrying the clock reading, tick count, uptime, set
// status and alignment flag.
//
// A new item can be taken in every cycle while m_tready is high; the clock
// state is updated in the stage after the input register, so each item
// sees the state left by the one before. The stages after it split the
// elapsed-tick division into a reciprocal multiply, a remainder correction
// and the final scaling to microseconds.
//
// When the receiver holds m_tready low the finished result waits in the
// output register, and the earlier stages keep filling until every stage is
// occupied; only then does s_tready fall. Reset clears the tick count, the
// clock base and the alignment phase, and empties every stage.
module tick_wall_clock_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [0] rtc_present, [32:1] rtc_second, [33] rtc_write_ok,
    // [65:34] new_second, [97:66] new_micros, [103:98] zero
    input  logic [103:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] clock_second, [51:32] clock_micros, [83:52] tick_value,
    // [115:84] uptime_ms, [117:116] status, [118] is_aligned, [119] zero
    output logic [119:0] m_tdata
);
    import twc_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic        exec_valid_reg, exec_valid_next;
    logic        quot_valid_reg, quot_valid_next;
    logic        rem_valid_reg, rem_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic [119:0] out_data_reg;
    item_t       item_reg, item_in;
    exec_res_t   exec_res;
    div_res_t    div_res;
    logic [60:0] frac_prod;
    logic        s_fire, adv_in, adv_exec, adv_quot, load_out;
    logic [31:0] clock_second;
    logic [FRAC_W-1:0] clock_micros;

    // Each stage moves on when the one ahead is empty or moving itself.
    assign load_out = rem_valid_reg && (!out_valid_reg || m_tready);
    assign adv_quot = quot_valid_reg && (!rem_valid_reg || load_out);
    assign adv_exec = exec_valid_reg && (!quot_valid_reg || adv_quot);
    assign adv_in   = in_valid_reg && (!exec_valid_reg || adv_exec);
    assign s_tready = !in_valid_reg || adv_in;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next   = s_fire || (in_valid_reg && !adv_in);
    assign exec_valid_next = adv_in || (exec_valid_reg && !adv_exec);
    assign quot_valid_next = adv_exec || (quot_valid_reg && !adv_quot);
    assign rem_valid_next  = adv_quot || (rem_valid_reg && !load_out);
    assign out_valid_next  = load_out || (out_valid_reg && !m_tready);

    // The set fraction in whole ticks is worked out ahead of the input
    // register, so the state stage only has a subtraction to do.
    assign frac_prod = 61'(s_tdata[85:66]) * 61'(FRAC_RECIP);

    always_comb
    begin
        item_in.mode         = s_tuser;
        item_in.rtc_present  = s_tdata[0];
        item_in.rtc_second   = s_tdata[32:1];
        item_in.rtc_write_ok = s_tdata[33];
        item_in.new_second   = s_tdata[65:34];
        item_in.new_micros   = s_tdata[97:66];
        item_in.frac_ticks   = frac_prod[FRAC_SHIFT+FRAC_W-1:FRAC_SHIFT];
    end

    twc_exec u_exec (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv_in),
        .item    (item_reg),
        .res_reg (exec_res)
    );

    twc_div u_div (
        .clk      (clk),
        .en_quot  (adv_exec),
        .en_rem   (adv_quot),
        .exec_res (exec_res),
        .div_reg  (div_res)
    );

    // Before alignment a read passes the RTC second straight through, and ticks
    // and sets report second zero; in all these cases the fraction is zero.
    assign clock_second = div_res.use_elapsed ? (div_res.base_or_raw + div_res.quot)
                                              : div_res.base_or_raw;
    assign clock_micros = div_res.use_elapsed
                          ? FRAC_W'(FRAC_W'(div_res.rem) * FRAC_W'(MICROS_PER_TICK))
                          : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            exec_valid_reg <= 1'b0;
            quot_valid_reg <= 1'b0;
            rem_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            exec_valid_reg <= exec_valid_next;
            quot_valid_reg <= quot_valid_next;
            rem_valid_reg  <= rem_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            item_reg <= item_in;
        if (load_out)
            out_data_reg <= {1'b0, div_res.aligned, div_res.status, div_res.uptime,
                             div_res.tick, clock_micros, clock_second};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
